/* hw/rtl/rv32dec_pkg.sv */
// Package for the RV32I instruction decoder: operation codes, major opcodes,
// system words and the decoded result type shared by the decode unit and the top level.
// No dependencies.
package rv32dec_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 6;
  localparam int unsigned RegW  = 5;
  localparam int unsigned ImmW  = 21;

  // Major opcodes, bits 6..0 of the instruction word.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [WordW-1:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [WordW-1:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Dense operation codes.
  localparam logic [OpW-1:0] OP_ILLEGAL = 6'd0;
  localparam logic [OpW-1:0] OP_LUI     = 6'd1;
  localparam logic [OpW-1:0] OP_AUIPC   = 6'd2;
  localparam logic [OpW-1:0] OP_JAL     = 6'd3;
  localparam logic [OpW-1:0] OP_JALR    = 6'd4;
  localparam logic [OpW-1:0] OP_BEQ     = 6'd5;
  localparam logic [OpW-1:0] OP_BNE     = 6'd6;
  localparam logic [OpW-1:0] OP_BLT     = 6'd7;
  localparam logic [OpW-1:0] OP_BGE     = 6'd8;
  localparam logic [OpW-1:0] OP_BLTU    = 6'd9;
  localparam logic [OpW-1:0] OP_BGEU    = 6'd10;
  localparam logic [OpW-1:0] OP_LB      = 6'd11;
  localparam logic [OpW-1:0] OP_LH      = 6'd12;
  localparam logic [OpW-1:0] OP_LW      = 6'd13;
  localparam logic [OpW-1:0] OP_LBU     = 6'd14;
  localparam logic [OpW-1:0] OP_LHU     = 6'd15;
  localparam logic [OpW-1:0] OP_SB      = 6'd16;
  localparam logic [OpW-1:0] OP_SH      = 6'd17;
  localparam logic [OpW-1:0] OP_SW      = 6'd18;
  localparam logic [OpW-1:0] OP_ADDI    = 6'd19;
  localparam logic [OpW-1:0] OP_SLTI    = 6'd20;
  localparam logic [OpW-1:0] OP_SLTIU   = 6'd21;
  localparam logic [OpW-1:0] OP_XORI    = 6'd22;
  localparam logic [OpW-1:0] OP_ORI     = 6'd23;
  localparam logic [OpW-1:0] OP_ANDI    = 6'd24;
  localparam logic [OpW-1:0] OP_SLLI    = 6'd25;
  localparam logic [OpW-1:0] OP_SRLI    = 6'd26;
  localparam logic [OpW-1:0] OP_SRAI    = 6'd27;
  localparam logic [OpW-1:0] OP_ADD     = 6'd28;
  localparam logic [OpW-1:0] OP_SUB     = 6'd29;
  localparam logic [OpW-1:0] OP_SLL     = 6'd30;
  localparam logic [OpW-1:0] OP_SLT     = 6'd31;
  localparam logic [OpW-1:0] OP_SLTU    = 6'd32;
  localparam logic [OpW-1:0] OP_XOR     = 6'd33;
  localparam logic [OpW-1:0] OP_SRL     = 6'd34;
  localparam logic [OpW-1:0] OP_SRA     = 6'd35;
  localparam logic [OpW-1:0] OP_OR      = 6'd36;
  localparam logic [OpW-1:0] OP_AND     = 6'd37;
  localparam logic [OpW-1:0] OP_ECALL   = 6'd38;
  localparam logic [OpW-1:0] OP_EBREAK  = 6'd39;
  localparam logic [OpW-1:0] OP_CSRRW   = 6'd40;
  localparam logic [OpW-1:0] OP_CSRRS   = 6'd41;
  localparam logic [OpW-1:0] OP_CSRRC   = 6'd42;
  localparam logic [OpW-1:0] OP_CSRRWI  = 6'd43;
  localparam logic [OpW-1:0] OP_CSRRSI  = 6'd44;
  localparam logic [OpW-1:0] OP_CSRRCI  = 6'd45;

  // One decoded instruction.
  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [RegW-1:0]         dest_reg;
    logic [RegW-1:0]         src1_reg;
    logic [RegW-1:0]         src2_reg;
    logic signed [ImmW-1:0]  immediate;
    logic [WordW-1:0]        target_address;
  } dec_result_t;

endpackage

/* hw/rtl/rv32dec_decode.sv */
// Combinational RV32I decode: operation code, register fields, immediate and
// branch/jal target from one instruction word and its address. Uses rv32dec_pkg.
module rv32dec_decode (
  input  logic [rv32dec_pkg::WordW-1:0] instr_word,
  input  logic [rv32dec_pkg::WordW-1:0] instr_addr,
  output rv32dec_pkg::dec_result_t      result
);
  import rv32dec_pkg::*;

  logic [6:0]      opcode;
  logic [2:0]      funct3;
  logic [6:0]      funct7;
  logic [ImmW-1:0] imm_i;
  logic [ImmW-1:0] imm_s;
  logic [ImmW-1:0] imm_b;
  logic [ImmW-1:0] imm_j;
  logic [ImmW-1:0] imm_u;
  logic [ImmW-1:0] imm_shamt;
  logic [ImmW-1:0] imm_csr;
  logic [OpW-1:0]  op;
  logic [ImmW-1:0] imm;
  logic            use_target;

  assign opcode = instr_word[6:0];
  assign funct3 = instr_word[14:12];
  assign funct7 = instr_word[31:25];

  assign imm_i     = {{9{instr_word[31]}}, instr_word[31:20]};
  assign imm_s     = {{9{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
  assign imm_b     = {{8{instr_word[31]}}, instr_word[31], instr_word[7],
                      instr_word[30:25], instr_word[11:8], 1'b0};
  assign imm_j     = {instr_word[31], instr_word[19:12], instr_word[20],
                      instr_word[30:21], 1'b0};
  assign imm_u     = {1'b0, instr_word[31:12]};
  assign imm_shamt = {16'd0, instr_word[24:20]};
  assign imm_csr   = {9'd0, instr_word[31:20]};

  always_comb begin
    op         = OP_ILLEGAL;
    imm        = '0;
    use_target = 1'b0;
    case (opcode)
      OPC_LUI: begin
        op  = OP_LUI;
        imm = imm_u;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        imm = imm_u;
      end
      OPC_JAL: begin
        op         = OP_JAL;
        imm        = imm_j;
        use_target = 1'b1;
      end
      OPC_JALR: begin
        op  = OP_JALR;
        imm = imm_i;
      end
      OPC_BRANCH: begin
        case (funct3)
          3'd0:    op = OP_BEQ;
          3'd1:    op = OP_BNE;
          3'd4:    op = OP_BLT;
          3'd5:    op = OP_BGE;
          3'd6:    op = OP_BLTU;
          3'd7:    op = OP_BGEU;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm        = imm_b;
          use_target = 1'b1;
        end
      end
      OPC_LOAD: begin
        case (funct3)
          3'd0:    op = OP_LB;
          3'd1:    op = OP_LH;
          3'd2:    op = OP_LW;
          3'd4:    op = OP_LBU;
          3'd5:    op = OP_LHU;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm = imm_i;
        end
      end
      OPC_STORE: begin
        case (funct3)
          3'd0:    op = OP_SB;
          3'd1:    op = OP_SH;
          3'd2:    op = OP_SW;
          default: op = OP_ILLEGAL;
        endcase
        if (op != OP_ILLEGAL) begin
          imm = imm_s;
        end
      end
      OPC_OPIMM: begin
        imm = imm_i;
        case (funct3)
          3'd0: op = OP_ADDI;
          3'd1: begin
            op  = OP_SLLI;
            imm = imm_shamt;
          end
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: begin
            // Only bit 30 separates the two right shifts.
            op  = instr_word[30] ? OP_SRAI : OP_SRLI;
            imm = imm_shamt;
          end
          3'd6: op = OP_ORI;
          3'd7: op = OP_ANDI;
          default: op = OP_ILLEGAL;
        endcase
      end
      OPC_OP: begin
        case (funct3)
          3'd0: begin
            if (funct7 == F7_BASE) begin
              op = OP_ADD;
            end else if (funct7 == F7_ALT) begin
              op = OP_SUB;
            end else begin
              op = OP_ILLEGAL;
            end
          end
          3'd1: op = OP_SLL;
          3'd2: op = OP_SLT;
          3'd3: op = OP_SLTU;
          3'd4: op = OP_XOR;
          3'd5: begin
            if (funct7 == F7_BASE) begin
              op = OP_SRL;
            end else if (funct7 == F7_ALT) begin
              op = OP_SRA;
            end else begin
              op = OP_ILLEGAL;
            end
          end
          3'd6: op = OP_OR;
          3'd7: op = OP_AND;
          default: op = OP_ILLEGAL;
        endcase
      end
      OPC_SYSTEM: begin
        if (instr_word == WORD_ECALL) begin
          op = OP_ECALL;
        end else if (instr_word == WORD_EBREAK) begin
          op = OP_EBREAK;
        end else begin
          case (funct3)
            3'd1:    op = OP_CSRRW;
            3'd2:    op = OP_CSRRS;
            3'd3:    op = OP_CSRRC;
            3'd5:    op = OP_CSRRWI;
            3'd6:    op = OP_CSRRSI;
            3'd7:    op = OP_CSRRCI;
            default: op = OP_ILLEGAL;
          endcase
          if (op != OP_ILLEGAL) begin
            imm = imm_csr;
          end
        end
      end
      default: begin
        op = OP_ILLEGAL;
      end
    endcase
  end

  assign result.operation      = op;
  assign result.dest_reg       = instr_word[11:7];
  assign result.src1_reg       = instr_word[19:15];
  assign result.src2_reg       = instr_word[24:20];
  assign result.immediate      = imm;
  assign result.target_address = use_target
                                 ? instr_addr + {{(WordW-ImmW){imm[ImmW-1]}}, imm}
                                 : '0;

endmodule

/* hw/rtl/rv32i_instruction_decoder.sv */
// Top level of the RV32I instruction decoder: input register, decode unit and
// result register on two stream channels. Uses rv32dec_pkg and rv32dec_decode.
//
//   Channel | Direction | Payload (tdata, lowest bit first)
//   --------+-----------+----------------------------------------------------
//   in_     | sink      | instruction_word[31:0], instruction_address[63:32]
//   out_    | source    | operation[5:0], dest_reg[10:6], src1_reg[15:11],
//           |           | src2_reg[20:16], immediate[41:21],
//           |           | target_address[73:42], zero fill [79:74]
//
// An accepted item is loaded into the input register, and its decoded result
// is loaded into the result register once that register may load.
// One item is accepted every cycle while the output side takes results.
// Reset (rst_n low, synchronous) empties both stages; payload is not cleared.
// A stalled output holds its result; the input register keeps its item, and
// in_tready drops only when both stages are full and out_tready is low.
module rv32i_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // instruction_word [31:0], instruction_address [63:32]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // operation [5:0], dest_reg [10:6], src1_reg [15:11], src2_reg [20:16],
  // immediate [41:21], target_address [73:42], zeros [79:74]
  output logic [79:0] out_tdata
);
  import rv32dec_pkg::*;

  // Stage one holds the raw item; stage two holds the decoded result.
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [WordW-1:0]     s1_word_r;
  logic [WordW-1:0]     s1_addr_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  dec_result_t          out_res_r;
  dec_result_t          dec_res;
  logic                 out_load;
  logic                 in_take;

  // The result register may load when it is empty or its item leaves now.
  assign out_load  = !out_valid_r || out_tready;
  // The input register may load when empty or when its item moves on.
  assign in_tready = !s1_valid_r || out_load;
  assign in_take   = in_tvalid && in_tready;

  rv32dec_decode u_decode (
    .instr_word (s1_word_r),
    .instr_addr (s1_addr_r),
    .result     (dec_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_tdata[31:0];
      s1_addr_r <= in_tdata[63:32];
    end
    if (out_load && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       out_res_r.target_address,
                       out_res_r.immediate,
                       out_res_r.src2_reg,
                       out_res_r.src1_reg,
                       out_res_r.dest_reg,
                       out_res_r.operation};

  // A held item in stage one must survive a stalled output.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("input stage lost an item during an output stall");

  // Only jal and the branches carry a target.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.target_address != '0) |->
      (out_res_r.operation == OP_JAL || out_res_r.operation == OP_BEQ ||
       out_res_r.operation == OP_BNE || out_res_r.operation == OP_BLT ||
       out_res_r.operation == OP_BGE || out_res_r.operation == OP_BLTU ||
       out_res_r.operation == OP_BGEU))
    else $error("target set for an operation that has none");

  // Illegal words carry no immediate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.operation == OP_ILLEGAL) |->
      (out_res_r.immediate == '0))
    else $error("illegal instruction with a nonzero immediate");

  // A result appears only when stage one held an item the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result appeared without a source item");

  // Reset leaves the result register empty.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
